// ===== hdl/vrq_pkg.sv =====
package vrq_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 32;
	localparam int ID_BITS_DEFAULT     = 16;
	localparam int KEY_W               = 64;
	localparam int TID_W               = 16;
	localparam int CNT_OUT_W           = 6;
	localparam int S_TDATA_W           = 88;
	localparam int M_TDATA_W           = 152;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_STEAL  = 2'd3
	} vrq_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} vrq_status_t;

	typedef struct packed {
		vrq_op_t op;
		logic    commit;
	} vrq_cmd_t;

	typedef struct packed {
		logic valid;
		logic locked;
		logic ahead;
		logic hit;
		logic sel;
		logic take;
		logic cand;
	} vrq_flags_t;

	localparam vrq_flags_t LEFT_EDGE = '{valid: 1'b0, locked: 1'b0, ahead: 1'b1,
		hit: 1'b0, sel: 1'b0, take: 1'b0, cand: 1'b0};
	localparam vrq_flags_t RIGHT_EDGE = '{valid: 1'b0, locked: 1'b0, ahead: 1'b0,
		hit: 1'b0, sel: 1'b0, take: 1'b0, cand: 1'b0};

endpackage

// ===== hdl/vrq_cell.sv =====
module vrq_cell import vrq_pkg::*; #(
	parameter int ID_BITS = ID_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vrq_cmd_t           cmd,
	input  logic [KEY_W-1:0]   new_key,
	input  logic [ID_BITS-1:0] new_owner,
	input  logic               new_locked,
	input  vrq_flags_t         left_flags,
	input  logic [KEY_W-1:0]   left_key,
	input  logic [ID_BITS-1:0] left_owner,
	input  vrq_flags_t         right_flags,
	input  logic [KEY_W-1:0]   right_key,
	input  logic [ID_BITS-1:0] right_owner,
	output vrq_flags_t         flags,
	output logic [KEY_W-1:0]   key,
	output logic [ID_BITS-1:0] owner
);

	logic               valid_q;
	logic               locked_q;
	logic [KEY_W-1:0]   key_q;
	logic [ID_BITS-1:0] owner_q;
	logic               own_cand;
	logic               sel;
	logic               load;
	logic               nxt_valid;
	logic               nxt_locked;
	logic [KEY_W-1:0]   nxt_key;
	logic [ID_BITS-1:0] nxt_owner;

	assign own_cand = valid_q && !locked_q;

	always_comb begin
		case (cmd.op)
			OP_POP:    sel = valid_q && !left_flags.valid;
			OP_REMOVE: sel = valid_q && (owner_q == new_owner);
			OP_STEAL:  sel = own_cand && !right_flags.cand;
			default:   sel = 1'b0;
		endcase
	end

	always_comb begin
		flags.valid  = valid_q;
		flags.locked = locked_q;
		flags.ahead  = valid_q && ((key_q < new_key) ||
			((key_q == new_key) && (owner_q < new_owner)));
		flags.hit    = valid_q && (owner_q == new_owner);
		flags.sel    = sel;
		flags.take   = left_flags.take || sel;
		flags.cand   = right_flags.cand || own_cand;
	end

	assign key   = key_q;
	assign owner = owner_q;

	// insert shifts right from the slot, removal shifts left from the slot
	always_comb begin
		load       = 1'b0;
		nxt_valid  = valid_q;
		nxt_locked = locked_q;
		nxt_key    = key_q;
		nxt_owner  = owner_q;
		if (cmd.op == OP_INSERT) begin
			if (!flags.ahead) begin
				load = 1'b1;
				if (left_flags.ahead) begin
					nxt_valid  = 1'b1;
					nxt_locked = new_locked;
					nxt_key    = new_key;
					nxt_owner  = new_owner;
				end else begin
					nxt_valid  = left_flags.valid;
					nxt_locked = left_flags.locked;
					nxt_key    = left_key;
					nxt_owner  = left_owner;
				end
			end
		end else if (flags.take) begin
			load       = 1'b1;
			nxt_valid  = right_flags.valid;
			nxt_locked = right_flags.locked;
			nxt_key    = right_key;
			nxt_owner  = right_owner;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.commit && load) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && load) begin
			locked_q <= nxt_locked;
			key_q    <= nxt_key;
			owner_q  <= nxt_owner;
		end
	end

endmodule

// ===== hdl/vruntime_run_queue.sv =====
// Run queue of thread entries kept sorted by virtual runtime, lower thread id first
// on ties, in a row of cells where cell 0 always holds the head. Each request is
// first registered (applying the wake normalization against the tracked minimum),
// then executed: every cell compares against it and shifts toward or away from its
// neighbor, with the result loaded into the output register. The next request is
// taken while that result waits; a request is held in the execute state only while
// the previous result has not been taken. Request: tuser is the opcode (insert,
// pop, remove by id, steal last unpinned). Result: tuser is the status (ok, empty
// or not found, already queued, full). Steal resolves its slot through a carry
// chain that ripples along the cells; removals shift through another such chain.
module vruntime_run_queue import vrq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
	parameter int ID_BITS     = ID_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// thread_id, run_time, wake_normalize, pinned, zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// opcode
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_thread_id, out_run_time, queue_count, min_run_time, zero fill
	output logic [M_TDATA_W-1:0] m_tdata,
	// status
	output logic [1:0]           m_tuser
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t             state_q;
	vrq_op_t            op_s1;
	logic [ID_BITS-1:0] id_s1;
	logic [KEY_W-1:0]   rt_s1;
	logic [KEY_W-1:0]   rt_raw_s1;
	logic               pin_s1;

	logic [KEY_W-1:0]   min_q;
	logic [CW-1:0]      count_q;

	logic               m_valid_q;
	vrq_status_t        status_q;
	logic [TID_W-1:0]   oid_q;
	logic [KEY_W-1:0]   ort_q;
	logic [CNT_OUT_W-1:0] ocount_q;
	logic [KEY_W-1:0]   omin_q;

	logic [TID_W-1:0]   in_tid;
	logic [KEY_W-1:0]   in_rt;
	logic               in_wake;
	logic               in_pin;
	logic [31:0]        in_id_wide;
	logic [KEY_W-1:0]   in_rt_norm;
	logic               accept;
	logic               go;

	vrq_cmd_t           cmd;
	vrq_flags_t         flags_w [QUEUE_DEPTH];
	logic [KEY_W-1:0]   key_w   [QUEUE_DEPTH];
	logic [ID_BITS-1:0] owner_w [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_vec;
	logic [QUEUE_DEPTH-1:0] hit_vec;
	logic [QUEUE_DEPTH-1:0] sel_vec;

	logic               dup;
	logic               full;
	logic               found;
	logic               ins_ok;
	logic [KEY_W-1:0]   sel_key;
	logic [ID_BITS-1:0] sel_owner;
	logic [KEY_W-1:0]   head_key;
	logic [31:0]        sel_owner_wide;
	logic [31:0]        id_wide_s1;
	logic [31:0]        count_wide;

	vrq_status_t        nxt_status;
	logic [TID_W-1:0]   nxt_oid;
	logic [KEY_W-1:0]   nxt_ort;
	logic [CW-1:0]      nxt_count;
	logic [KEY_W-1:0]   nxt_min;

	assign in_tid     = s_tdata[15:0];
	assign in_rt      = s_tdata[79:16];
	assign in_wake    = s_tdata[80];
	assign in_pin     = s_tdata[81];
	assign in_id_wide = {16'b0, in_tid};
	assign in_rt_norm = (in_wake && (in_rt < min_q)) ? min_q : in_rt;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign go       = (state_q == S_EXEC) && (!m_valid_q || m_tready);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= vrq_op_t'(s_tuser);
			id_s1     <= in_id_wide[ID_BITS-1:0];
			rt_s1     <= in_rt_norm;
			rt_raw_s1 <= in_rt;
			pin_s1    <= in_pin;
		end
	end

	// cell row
	assign cmd.op     = op_s1;
	assign cmd.commit = go && ((op_s1 == OP_INSERT) ? ins_ok : found);

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		vrq_flags_t         lf;
		vrq_flags_t         rf;
		logic [KEY_W-1:0]   lk;
		logic [KEY_W-1:0]   rk;
		logic [ID_BITS-1:0] lo;
		logic [ID_BITS-1:0] ro;

		if (g == 0) begin : g_left_edge
			assign lf = LEFT_EDGE;
			assign lk = '0;
			assign lo = '0;
		end else begin : g_left
			assign lf = flags_w[g-1];
			assign lk = key_w[g-1];
			assign lo = owner_w[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_right_edge
			assign rf = RIGHT_EDGE;
			assign rk = '0;
			assign ro = '0;
		end else begin : g_right
			assign rf = flags_w[g+1];
			assign rk = key_w[g+1];
			assign ro = owner_w[g+1];
		end

		vrq_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_key    (rt_s1),
			.new_owner  (id_s1),
			.new_locked (pin_s1),
			.left_flags (lf),
			.left_key   (lk),
			.left_owner (lo),
			.right_flags(rf),
			.right_key  (rk),
			.right_owner(ro),
			.flags      (flags_w[g]),
			.key        (key_w[g]),
			.owner      (owner_w[g])
		);

		assign valid_vec[g] = flags_w[g].valid;
		assign hit_vec[g]   = flags_w[g].hit;
		assign sel_vec[g]   = flags_w[g].sel;
	end

	always_comb begin
		sel_key   = '0;
		sel_owner = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sel_key   = sel_key   | (key_w[i]   & {KEY_W{sel_vec[i]}});
			sel_owner = sel_owner | (owner_w[i] & {ID_BITS{sel_vec[i]}});
		end
	end

	assign dup    = |hit_vec;
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign found  = |sel_vec;
	assign ins_ok = !dup && !full;

	// head after removal: the cell behind the head moves up when the head leaves
	assign head_key       = sel_vec[0] ? key_w[1] : key_w[0];
	assign sel_owner_wide = 32'(sel_owner);
	assign id_wide_s1     = 32'(id_s1);

	always_comb begin
		nxt_count = count_q;
		nxt_min   = min_q;
		if (op_s1 == OP_INSERT) begin
			nxt_oid = id_wide_s1[TID_W-1:0];
			nxt_ort = rt_raw_s1;
			if (dup) begin
				nxt_status = ST_DUP;
			end else if (full) begin
				nxt_status = ST_FULL;
			end else begin
				nxt_status = ST_OK;
				nxt_ort    = rt_s1;
				nxt_count  = count_q + CW'(1);
				if ((rt_s1 < min_q) || (min_q == '0)) begin
					nxt_min = rt_s1;
				end
			end
		end else if (found) begin
			nxt_status = ST_OK;
			nxt_oid    = sel_owner_wide[TID_W-1:0];
			nxt_ort    = sel_key;
			nxt_count  = count_q - CW'(1);
			if ((count_q > CW'(1)) && (head_key > min_q)) begin
				nxt_min = head_key;
			end
		end else begin
			nxt_status = ST_NONE;
			nxt_oid    = '0;
			nxt_ort    = '0;
		end
	end

	assign count_wide = 32'(nxt_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			min_q     <= '0;
			count_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
					if (m_tready) begin
						m_valid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (go) begin
						state_q   <= S_IDLE;
						m_valid_q <= 1'b1;
						min_q     <= nxt_min;
						count_q   <= nxt_count;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q <= nxt_status;
			oid_q    <= nxt_oid;
			ort_q    <= nxt_ort;
			ocount_q <= count_wide[CNT_OUT_W-1:0];
			omin_q   <= nxt_min;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {2'b0, omin_q, ocount_q, ort_q, oid_q};

`ifndef SYNTHESIS
	// occupied cells are packed from the head
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec[QUEUE_DEPTH-1:1] & ~valid_vec[QUEUE_DEPTH-2:0]) == '0)
		else $error("hole in cell row");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(valid_vec)))
		else $error("entry count out of step with cells");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> $onehot0(sel_vec))
		else $error("more than one cell selected");

	assert property (@(posedge clk) disable iff (!arst_n)
		(go && (op_s1 != OP_INSERT)) |=> (min_q >= $past(min_q)))
		else $error("minimum fell on removal");

	assert property (@(posedge clk) disable iff (!arst_n)
		(go && (op_s1 == OP_INSERT) && ins_ok) |=> valid_vec[0])
		else $error("head empty after insert");
`endif

endmodule
